[src/nnfs_pkg.sv]
// ----------------------------------------------------------------------------
// nnfs_pkg
// Shared types and constants of the nearest-neighbor frame scaler: register
// indexes, the controller state type and the command and status bundles.
// ----------------------------------------------------------------------------
package nnfs_pkg;

    // width of a dimension register and of one color component
    localparam int CFG_W   = 9;
    localparam int COMP_W  = 8;
    localparam int PIX_W   = 3 * COMP_W;
    localparam int COORD_W = 8;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

    // item kinds carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] src_width;
        logic [CFG_W-1:0] src_height;
        logic [CFG_W-1:0] dst_width;
        logic [CFG_W-1:0] dst_height;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_WAIT,
        S_LD_WR,
        S_EM_WRAP,
        S_EM_MUL,
        S_DIVR_GO,
        S_DIVR,
        S_DIVC_GO,
        S_DIVC,
        S_EM_ADDR,
        S_EM_READ,
        S_EM_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic ld_write;
        logic em_wrap;
        logic em_mul;
        logic div_start;
        logic div_col;
        logic save_row;
        logic save_col;
        logic em_addr;
        logic em_read;
        logic em_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[src/nnfs_ram.sv]
// ----------------------------------------------------------------------------
// nnfs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nnfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/nnfs_div.sv]
// ----------------------------------------------------------------------------
// nnfs_div
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in QW bits, so the upper DW bits of the dividend start as the remainder.
// ----------------------------------------------------------------------------
module nnfs_div #(
    parameter int QW = 8,
    parameter int DW = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [QW+DW-1:0] i_dividend,
    input  logic [DW-1:0]    i_divisor,
    output logic             o_done,
    output logic [QW-1:0]    o_quot
);

    localparam int CW = $clog2(QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [QW-1:0] r_q;
    logic [DW:0]   trial;
    logic          ge;

    // one trial subtraction per step
    always_comb begin
        trial = {r_rem, r_q[QW-1]};
        ge    = (trial >= {1'b0, r_div});
    end

    // control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[QW+DW-1:QW];
            r_q   <= i_dividend[QW-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? DW'(trial - {1'b0, r_div}) : DW'(trial);
            r_q   <= QW'({r_q, ge});
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[src/nnfs_datapath.sv]
// ----------------------------------------------------------------------------
// nnfs_datapath
// Frame store, load index, output position, coordinate scaling and the output
// register of the scaler, stepped by commands from the controller.
// ----------------------------------------------------------------------------
module nnfs_datapath
    import nnfs_pkg::*;
#(
    parameter int MAX_DIM = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [PIX_W-1:0]       i_pix,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [PIX_W+2*COORD_W-1:0] o_m_tdata,
    output logic                   o_m_tlast
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CRD_W  = $clog2(MAX_DIM);
    localparam int PROD_W = CRD_W + DIM_W;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int SIZE_W = $clog2(DEPTH + 1);

    // clamp a dimension register to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    logic [DIM_W-1:0]  sw, sh, dw, dh;
    logic [SIZE_W-1:0] r_size;
    logic [AW-1:0]     r_ld_idx;
    logic [AW-1:0]     ld_addr;
    logic [SIZE_W-1:0] ld_nxt;
    logic [PIX_W-1:0]  r_pix;
    logic [CRD_W-1:0]  r_row, r_col;
    logic [CRD_W:0]    row_nxt, col_nxt;
    logic [PROD_W-1:0] r_prod_r, r_prod_c;
    logic [CRD_W-1:0]  r_srow, r_scol;
    logic [PROD_W-1:0] r_base;
    logic [AW-1:0]     rd_addr;
    logic [PIX_W-1:0]  rd_data;
    logic              div_done;
    logic [CRD_W-1:0]  div_q;
    logic [PROD_W-1:0] div_dividend;
    logic [DIM_W-1:0]  div_divisor;
    logic              frame_end;
    logic              r_out_valid;
    logic [PIX_W+2*COORD_W-1:0] r_out_data;
    logic              r_out_last;

    // effective dimensions
    always_comb begin
        sw = eff_dim(i_cfg.src_width);
        sh = eff_dim(i_cfg.src_height);
        dw = eff_dim(i_cfg.dst_width);
        dh = eff_dim(i_cfg.dst_height);
    end

    // source frame size, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_size <= SIZE_W'(sw * sh);
    end

    // captured source pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix <= i_pix;
        end
    end

    // load index wraps before and after the write
    always_comb begin
        ld_addr = (SIZE_W'(r_ld_idx) >= r_size) ? '0 : r_ld_idx;
        ld_nxt  = SIZE_W'(ld_addr) + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_idx <= '0;
        end else if (i_cmd.ld_write) begin
            r_ld_idx <= (ld_nxt >= r_size) ? '0 : AW'(ld_nxt);
        end
    end

    // output position: restart check and raster step
    always_comb begin
        col_nxt   = {1'b0, r_col} + 1'b1;
        row_nxt   = {1'b0, r_row} + 1'b1;
        frame_end = (r_row == CRD_W'(dh - 1'b1)) && (r_col == CRD_W'(dw - 1'b1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.em_wrap) begin
            if ((r_row >= dh) || (r_col >= dw)) begin
                r_row <= '0;
                r_col <= '0;
            end
        end else if (i_cmd.em_out && o_sts.out_free) begin
            if (col_nxt >= dw) begin
                r_col <= '0;
                r_row <= (row_nxt >= dh) ? '0 : CRD_W'(row_nxt);
            end else begin
                r_col <= CRD_W'(col_nxt);
            end
        end
    end

    // scaled products ahead of the divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.em_mul) begin
            r_prod_r <= PROD_W'(r_row * sh);
            r_prod_c <= PROD_W'(r_col * sw);
        end
    end

    // shared divider, row first then column
    assign div_dividend = i_cmd.div_col ? r_prod_c : r_prod_r;
    assign div_divisor  = i_cmd.div_col ? dw : dh;

    nnfs_div #(
        .QW (CRD_W),
        .DW (DIM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // source coordinates and row base address
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_row) begin
            r_srow <= div_q;
        end
        if (i_cmd.save_col) begin
            r_scol <= div_q;
        end
        if (i_cmd.em_addr) begin
            r_base <= PROD_W'(r_srow * sw);
        end
    end

    assign rd_addr = AW'(r_base + PROD_W'(r_scol));

    // frame store
    nnfs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.ld_write),
        .i_wr_addr (ld_addr),
        .i_wr_data (r_pix),
        .i_rd_en   (i_cmd.em_read),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.em_out && o_sts.out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.em_out && o_sts.out_free) begin
            r_out_data <= {COORD_W'(r_col), COORD_W'(r_row), rd_data};
            r_out_last <= frame_end;
        end
    end

    always_comb begin
        o_sts.div_done = div_done;
        o_sts.out_free = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

[src/nnfs_ctrl.sv]
// ----------------------------------------------------------------------------
// nnfs_ctrl
// Controller state machine: takes one item at a time and sequences the load
// write or the scaling, divide, read and output steps of an emit.
// ----------------------------------------------------------------------------
module nnfs_ctrl
    import nnfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_op,
    input  t_sts i_sts,
    output logic o_s_tready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (i_op == OP_EMIT) ? S_EM_WRAP : S_LD_WAIT;
                end
            end
            S_LD_WAIT: n_state = S_LD_WR;
            S_LD_WR:   n_state = S_IDLE;
            S_EM_WRAP: n_state = S_EM_MUL;
            S_EM_MUL:  n_state = S_DIVR_GO;
            S_DIVR_GO: n_state = S_DIVR;
            S_DIVR: begin
                if (i_sts.div_done) begin
                    n_state = S_DIVC_GO;
                end
            end
            S_DIVC_GO: n_state = S_DIVC;
            S_DIVC: begin
                if (i_sts.div_done) begin
                    n_state = S_EM_ADDR;
                end
            end
            S_EM_ADDR: n_state = S_EM_READ;
            S_EM_READ: n_state = S_EM_OUT;
            S_EM_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            S_LD_WAIT: ;
            S_LD_WR:   o_cmd.ld_write = 1'b1;
            S_EM_WRAP: o_cmd.em_wrap = 1'b1;
            S_EM_MUL:  o_cmd.em_mul = 1'b1;
            S_DIVR_GO: o_cmd.div_start = 1'b1;
            S_DIVR:    o_cmd.save_row = i_sts.div_done;
            S_DIVC_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_col   = 1'b1;
            end
            S_DIVC:    o_cmd.save_col = i_sts.div_done;
            S_EM_ADDR: o_cmd.em_addr = 1'b1;
            S_EM_READ: o_cmd.em_read = 1'b1;
            S_EM_OUT:  o_cmd.em_out = 1'b1;
            default: ;
        endcase
    end

endmodule

[src/nearest_neighbor_frame_scaler_core.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_frame_scaler_core
// Nearest-neighbor frame scaler with an APB register port and stream ports.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A load item (tuser = 0) writes its pixel
// into the frame store in raster order after a wait state that lets the
// registered frame size follow a register write. An emit item (tuser = 1)
// returns the next output pixel, using the shared restoring divider that
// produces one quotient bit a cycle, first for the source row and then for
// the source column, followed by one frame-store read. A finished pixel waits
// in the output register while the next item is taken in. Dimension
// registers act as 1 when zero and as MAX_DIM when larger; changing them
// resets no counter. The frame store is not cleared: read only what was
// loaded.
module nearest_neighbor_frame_scaler_core
    import nnfs_pkg::*;
#(
    parameter int MAX_DIM = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red_in, green_in, blue_in
    input  logic [0:0]  i_s_tuser,   // op
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // red_out, green_out, blue_out, out_row, out_col
    output logic        o_m_tlast    // frame_end
);

    t_cfg       r_cfg;
    t_cmd       cmd;
    t_sts       sts;
    logic       cfg_we;
    logic [1:0] cfg_idx;

    assign cfg_we   = i_psel && i_penable && i_pwrite;
    assign cfg_idx  = i_paddr[3:2];
    assign o_pready = 1'b1;

    // dimension registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= CFG_W'(256);
            r_cfg.src_height <= CFG_W'(256);
            r_cfg.dst_width  <= CFG_W'(256);
            r_cfg.dst_height <= CFG_W'(256);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:  r_cfg.src_width  <= i_pwdata[CFG_W-1:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= i_pwdata[CFG_W-1:0];
                REG_DST_WIDTH:  r_cfg.dst_width  <= i_pwdata[CFG_W-1:0];
                REG_DST_HEIGHT: r_cfg.dst_height <= i_pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  o_prdata = 32'(r_cfg.src_width);
            REG_SRC_HEIGHT: o_prdata = 32'(r_cfg.src_height);
            REG_DST_WIDTH:  o_prdata = 32'(r_cfg.dst_width);
            REG_DST_HEIGHT: o_prdata = 32'(r_cfg.dst_height);
            default:        o_prdata = '0;
        endcase
    end

    // controller
    nnfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser[0]),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    // datapath
    nnfs_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_pix      (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // a stalled result item holds steady until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled result changed");

    // placing a result shows it on the next cycle
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.em_out |=> o_m_tvalid)
        else $error("placed result not shown");

    // a result appears only after the controller placed one
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(cmd.em_out))
        else $error("result appeared without an emit");

    // the frame store is never written and read in the same cycle
    a_store_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.ld_write && cmd.em_read))
        else $error("frame store write and read together");

endmodule

[verif/nn_scale_checker.sv]
// ----------------------------------------------------------------------------
// nn_scale_checker
// Watches the register port and both item streams of the frame scaler, keeps
// its own copy of the frame store, frame size and output position, predicts
// every output pixel and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module nn_scale_checker
    import nnfs_pkg::*;
#(
    parameter int MAX_DIM = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    // input items
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // red_in, green_in, blue_in
    input  logic [0:0]  i_s_tuser,   // op
    // result items
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // red_out, green_out, blue_out, out_row, out_col
    input  logic        i_m_tlast,   // frame_end
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COMP_W-1:0]  red;
        logic [COMP_W-1:0]  green;
        logic [COMP_W-1:0]  blue;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               frame_end;
    } t_out_pixel;

    // own copy of the frame store, kept as the item carries it (red lowest)
    logic [PIX_W-1:0] frame_copy [0:MAX_DIM*MAX_DIM-1];
    logic [CFG_W-1:0] cfg_sw, cfg_sh, cfg_dw, cfg_dh;
    int unsigned      load_pos, emit_r, emit_c;
    t_out_pixel       pixels_due [$];
    int               mismatches = 0;

    // zero acts as one, anything above the store size as the store size
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic void write_cfg(input logic [1:0] reg_sel, input logic [CFG_W-1:0] v);
        case (reg_sel)
            REG_SRC_WIDTH:  cfg_sw = v;
            REG_SRC_HEIGHT: cfg_sh = v;
            REG_DST_WIDTH:  cfg_dw = v;
            REG_DST_HEIGHT: cfg_dh = v;
            default: ;
        endcase
    endfunction

    // load goes to the write pointer, which wraps at the source frame size
    function automatic void store_pixel(input logic [PIX_W-1:0] px);
        int unsigned frame_px;
        frame_px = clamp_dim(cfg_sw) * clamp_dim(cfg_sh);
        if (load_pos >= frame_px) load_pos = 0;
        frame_copy[load_pos] = px;
        load_pos++;
        if (load_pos >= frame_px) load_pos = 0;
    endfunction

    // next destination pixel in raster order, then advance the position
    function automatic t_out_pixel next_scaled_pixel();
        int unsigned sw, sh, dw, dh, srow, scol;
        logic [PIX_W-1:0] px;
        t_out_pixel p;
        sw = clamp_dim(cfg_sw);
        sh = clamp_dim(cfg_sh);
        dw = clamp_dim(cfg_dw);
        dh = clamp_dim(cfg_dh);
        // position left outside a shrunk frame restarts at the origin
        if (emit_r >= dh || emit_c >= dw) begin
            emit_r = 0;
            emit_c = 0;
        end
        srow = (emit_r * sh) / dh;
        scol = (emit_c * sw) / dw;
        px = frame_copy[srow * sw + scol];
        p.red       = px[7:0];
        p.green     = px[15:8];
        p.blue      = px[23:16];
        p.row       = emit_r[COORD_W-1:0];
        p.col       = emit_c[COORD_W-1:0];
        p.frame_end = (emit_r == dh - 1) && (emit_c == dw - 1);
        emit_c++;
        if (emit_c >= dw) begin
            emit_c = 0;
            emit_r++;
            if (emit_r >= dh) emit_r = 0;
        end
        return p;
    endfunction

    function automatic void check_pixel(input t_out_pixel got);
        t_out_pixel want;
        if (pixels_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected pixel rgb=%02x_%02x_%02x at (%0d,%0d) end=%0b",
                         $realtime, got.red, got.green, got.blue, got.row, got.col,
                         got.frame_end);
            return;
        end
        want = pixels_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
            || got.row !== want.row || got.col !== want.col
            || got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: pixel mismatch, expected rgb=%02x_%02x_%02x at (%0d,%0d) ",
                          "end=%0b, got rgb=%02x_%02x_%02x at (%0d,%0d) end=%0b"},
                         $realtime, want.red, want.green, want.blue, want.row, want.col,
                         want.frame_end, got.red, got.green, got.blue, got.row, got.col,
                         got.frame_end);
        end
    endfunction

    // everything is sampled at the clock edge, before the block updates
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_sw   = 9'd256;
            cfg_sh   = 9'd256;
            cfg_dw   = 9'd256;
            cfg_dh   = 9'd256;
            load_pos = 0;
            emit_r   = 0;
            emit_c   = 0;
            pixels_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_cfg(i_paddr[3:2], i_pwdata[CFG_W-1:0]);
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == OP_EMIT)
                    pixels_due.push_back(next_scaled_pixel());
                else
                    store_pixel(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready)
                check_pixel({i_m_tdata[7:0], i_m_tdata[15:8], i_m_tdata[23:16],
                             i_m_tdata[31:24], i_m_tdata[39:32], i_m_tlast});
        end
        o_mismatches <= mismatches;
        o_pending    <= pixels_due.size();
    end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the nearest-neighbor frame scaler: frame sizes set over the
// register port between phases, each phase loading a whole source frame and
// then mixing loads with output requests, with random gaps and stalls on both
// streams. The checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnfs_pkg::*;

    localparam int STORE_DIM = 256;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          mismatches;
    int          pending;

    // idle pattern state of each stream side
    int s_run_left = 0;
    bit s_quiet    = 1'b0;
    int m_run_left = 0;
    bit m_quiet    = 1'b0;

    nearest_neighbor_frame_scaler_core #(
        .MAX_DIM (STORE_DIM)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    nn_scale_checker #(
        .MAX_DIM (STORE_DIM)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // stretches of random waits alternate with stretches of none
    function automatic int draw_wait(inout int run_left, inout bit quiet);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 40);
            quiet    = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic int src_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > STORE_DIM) return STORE_DIM;
        return v;
    endfunction

    // all four frame size registers, upper data bits random
    task automatic set_frame(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                             input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] dh);
        logic [CFG_W-1:0] vals [4];
        logic [1:0]       sel  [4];
        logic [31:0]      word;
        vals = '{sw, sh, dw, dh};
        sel  = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT};
        for (int k = 0; k < 4; k++) begin
            word = $urandom;
            word[CFG_W-1:0] = vals[k];
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {sel[k], 2'b00};
            pwdata  <= word;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one item, held until the block takes it
    task automatic push_item(input logic op, input logic [23:0] rgb);
        int gap;
        gap = draw_wait(s_run_left, s_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rgb;
        do @(posedge clk); while (!s_tready);
    endtask

    // block idle: every pixel back, then room for a load still in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (40) @(posedge clk);
    endtask

    // whole source frame first, so no emit reads an unwritten entry
    task automatic run_phase(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                             input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] dh,
                             input int mix_len, input int emit_pct, inout int count);
        int frame_px;
        set_frame(sw, sh, dw, dh);
        frame_px = src_dim(sw) * src_dim(sh);
        repeat (frame_px) push_item(OP_LOAD, 24'($urandom));
        repeat (mix_len)
            push_item(($urandom_range(1, 100) <= emit_pct) ? OP_EMIT : OP_LOAD,
                      24'($urandom));
        drain();
        count += frame_px + mix_len;
    endtask

    // receiver with random stalls per item
    initial begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_wait(m_run_left, m_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial begin
        int               done_items;
        logic [CFG_W-1:0] sw, sh, dw, dh;
        done_items = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // source 3x2, zero destination width acting as one; extreme pixel values,
        // one extra load so the write pointer sits past the next frame
        set_frame(9'd3, 9'd2, 9'd0, 9'd3);
        push_item(OP_LOAD, 24'h000000);
        push_item(OP_LOAD, 24'hffffff);
        push_item(OP_LOAD, 24'haa55aa);
        push_item(OP_LOAD, 24'h55aa55);
        push_item(OP_LOAD, 24'h0f0f0f);
        push_item(OP_LOAD, 24'hf0f0f0);
        push_item(OP_LOAD, 24'($urandom));
        // frame end on the last row, then wrap
        repeat (4) push_item(OP_EMIT, 24'($urandom));
        drain();

        // one pixel source with zero height: load pointer beyond the frame;
        // width above the store size, emit row beyond the single-row frame
        set_frame(9'd1, 9'd0, 9'd511, 9'd0);
        push_item(OP_LOAD, 24'($urandom));
        repeat (3) push_item(OP_EMIT, 24'($urandom));
        drain();

        // small random frames
        while (done_items < 60) begin
            sw = CFG_W'($urandom_range(0, 8));
            sh = CFG_W'($urandom_range(0, 8));
            dw = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(257, 511))
                                             : CFG_W'($urandom_range(0, 12));
            dh = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(257, 511))
                                             : CFG_W'($urandom_range(0, 12));
            run_phase(sw, sh, dw, dh, $urandom_range(20, 60), 60, done_items);
        end

        // wide source and widest output row, columns past 127
        run_phase(9'd128, 9'd1, 9'd256, 9'd1, 130, 100, done_items);
        // tallest output column, rows past 127
        run_phase(9'd2, 9'd3, 9'd1, 9'd256, 130, 100, done_items);

        // one more small frame after the large ones
        repeat (1) begin
            sw = CFG_W'($urandom_range(1, 8));
            sh = CFG_W'($urandom_range(1, 8));
            dw = CFG_W'($urandom_range(1, 12));
            dh = CFG_W'($urandom_range(1, 12));
            run_phase(sw, sh, dw, dh, $urandom_range(20, 60), 60, done_items);
        end

        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[nearest_neighbor_frame_scaler_core.f]
src/nnfs_pkg.sv
src/nnfs_ram.sv
src/nnfs_div.sv
src/nnfs_datapath.sv
src/nnfs_ctrl.sv
src/nearest_neighbor_frame_scaler_core.sv
verif/nn_scale_checker.sv
verif/tb.sv
